// ===== src/imr_pkg.sv =====
// Shared types and constants for the 4x4 int8 matrix multiply with ReLU.
package imr_pkg;

	localparam int N      = 4;
	localparam int DW     = 8;
	localparam int PROD_W = 2 * DW;
	localparam int ACC_W  = PROD_W + $clog2(N);
	localparam int ACT_W  = 17;
	localparam int NE     = N * N;
	localparam int IDX_W  = $clog2(NE);
	localparam int STEP_W = $clog2(N);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NE - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N - 1);

	typedef struct packed {
		logic signed [DW-1:0] a_col0;
		logic signed [DW-1:0] a_col1;
		logic signed [DW-1:0] a_col2;
		logic signed [DW-1:0] a_col3;
		logic signed [DW-1:0] b_row0;
		logic signed [DW-1:0] b_row1;
		logic signed [DW-1:0] b_row2;
		logic signed [DW-1:0] b_row3;
	} in_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] raw_sum;
		logic [ACT_W-1:0]        activated;
		logic [IDX_W-1:0]        element_index;
		logic                    last_result;
	} out_t;

	// one queued beat: operands plus the end-of-matrix tag
	typedef struct packed {
		in_t  item;
		logic last;
	} q_entry_t;

endpackage

// ===== src/int8_matmul_relu_4x4.sv =====
// Top level of the 4x4 int8 matrix multiply with ReLU.
//
// Input channel (in_valid/in_ready/in_data): beat k carries column k of A and
// row k of B; four beats make one matrix. Output channel (out_valid/out_ready/
// out_data): sixteen beats per matrix in row-major order, each with raw sum,
// ReLU value, element index and a last mark on element 15.
// A front end counts beats and tags the fourth; a two-entry queue feeds the
// back end, which adds one full outer product per cycle, while a beat is queued,
// into sixteen accumulators. On the tagged beat the sums move into a result
// bank and the accumulators clear, so the next matrix accumulates while the
// bank drains. The first result follows the fourth beat through the queue,
// bank and output register. Throughput: one result per cycle while out_ready
// is high, set by the single drain port of the result bank.
// Input beats are taken while the queue has room; a new matrix's final beat
// waits until the bank is free.
// Reset (arst_n low) clears accumulators, beat count, queue and output valid.
// When the receiver stalls the output beat holds; the bank and then the queue
// fill, after which in_ready drops.
module int8_matmul_relu_4x4 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  imr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output imr_pkg::out_t out_data
);
	import imr_pkg::*;

	logic     push;
	logic     pop;
	logic     q_ready;
	logic     q_valid;
	q_entry_t push_data;
	q_entry_t q_data;

	imr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready)
	);

	imr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop)
	);

	imr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== src/imr_front.sv =====
// Front end: accepts input beats and tags the final beat of each matrix.
module imr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  imr_pkg::in_t    in_data,
	output logic            push,
	output imr_pkg::q_entry_t push_data,
	input  logic            q_ready
);
	import imr_pkg::*;

	logic [STEP_W-1:0] step_q;

	assign in_ready       = q_ready;
	assign push           = in_valid && q_ready;
	assign push_data.item = in_data;
	assign push_data.last = (step_q == LAST_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (push) begin
			step_q <= push_data.last ? '0 : step_q + 1'b1;
		end
	end

endmodule

// ===== src/imr_queue.sv =====
// Two-entry queue between front and back ends.
module imr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  imr_pkg::q_entry_t push_data,
	output logic              q_ready,
	output logic              q_valid,
	output imr_pkg::q_entry_t q_data,
	input  logic              pop
);
	import imr_pkg::*;

	q_entry_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign q_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/imr_back.sv =====
// Back end: outer-product accumulation, result bank and output drain.
module imr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  imr_pkg::q_entry_t q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output imr_pkg::out_t     out_data
);
	import imr_pkg::*;

	logic signed [DW-1:0]     a [N];
	logic signed [DW-1:0]     b [N];
	logic signed [PROD_W-1:0] prod [NE];
	logic signed [ACC_W-1:0]  sum [NE];
	logic signed [ACC_W-1:0]  acc_q [NE];
	logic signed [ACC_W-1:0]  bank_q [NE];
	logic                     bank_valid_q;
	logic [IDX_W-1:0]         cnt_q;
	logic                     out_valid_q;
	out_t                     out_q;
	logic                     out_load;
	logic                     bank_free;
	logic signed [ACC_W-1:0]  rd_val;

	assign a[0] = q_data.item.a_col0;
	assign a[1] = q_data.item.a_col1;
	assign a[2] = q_data.item.a_col2;
	assign a[3] = q_data.item.a_col3;
	assign b[0] = q_data.item.b_row0;
	assign b[1] = q_data.item.b_row1;
	assign b[2] = q_data.item.b_row2;
	assign b[3] = q_data.item.b_row3;

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			prod[e] = a[e / N] * b[e % N];
			sum[e]  = acc_q[e] + {{(ACC_W-PROD_W){prod[e][PROD_W-1]}}, prod[e]};
		end
	end

	assign out_load  = bank_valid_q && (!out_valid_q || out_ready);
	// bank may reload in the cycle its final element moves to the output register
	assign bank_free = !bank_valid_q || (out_load && cnt_q == LAST_IDX);
	assign pop       = q_valid && (!q_data.last || bank_free);
	assign rd_val    = bank_q[cnt_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NE; e++) acc_q[e] <= '0;
		end else if (pop) begin
			for (int e = 0; e < NE; e++) acc_q[e] <= q_data.last ? '0 : sum[e];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_data.last) begin
			for (int e = 0; e < NE; e++) bank_q[e] <= sum[e];
		end
		if (out_load) begin
			out_q.raw_sum       <= rd_val;
			out_q.activated     <= rd_val[ACC_W-1] ? '0 : rd_val[ACT_W-1:0];
			out_q.element_index <= cnt_q;
			out_q.last_result   <= (cnt_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && q_data.last) bank_valid_q <= 1'b1;
			else if (out_load && cnt_q == LAST_IDX) bank_valid_q <= 1'b0;
			if (out_load) cnt_q <= cnt_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/imr_checker.sv =====
// Port-level checker for the matrix multiply block, with its bind.
module imr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input imr_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input imr_pkg::out_t out_data
);
	import imr_pkg::*;

	logic [IDX_W-1:0] exp_idx_q;
	logic             out_beat;

	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_beat) begin
			exp_idx_q <= exp_idx_q + 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> out_data.element_index == exp_idx_q)
		else $error("result index out of row-major order");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> out_data.last_result == (out_data.element_index == LAST_IDX))
		else $error("last mark not on final element");

	a_relu: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> out_data.activated ==
			(out_data.raw_sum[ACC_W-1] ? '0 : out_data.raw_sum[ACT_W-1:0]))
		else $error("ReLU value does not match raw sum");

endmodule

bind int8_matmul_relu_4x4 imr_checker u_imr_checker (.*);
